### rtl/core/rtp_sequence_validator_top_macros.svh
// assertion macros used by the checker file
`ifndef RTP_SEQUENCE_VALIDATOR_TOP_MACROS_SVH
`define RTP_SEQUENCE_VALIDATOR_TOP_MACROS_SVH

// same-cycle implication, masked while in reset
`define RTPSV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked while in reset
`define RTPSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define RTPSV_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/rtpsv_pkg.sv
package rtpsv_pkg;

  localparam int SEQ_W      = 16;
  localparam int CNT_W      = 32;
  localparam int PROB_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int PEND_W     = SEQ_W + 1;
  localparam int OUT_W      = 3 * SEQ_W + CNT_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEQUENTIAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DROPOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISORDER   = 2'd2;

  localparam logic [PROB_W-1:0]     RST_MIN_SEQUENTIAL = 4'd2;
  localparam logic [CFG_DATA_W-1:0] RST_MAX_DROPOUT    = 15'd3000;
  localparam logic [CFG_DATA_W-1:0] RST_MAX_MISORDER   = 15'd100;

  // no 16-bit sequence number can match this
  localparam logic [PEND_W-1:0] NO_BAD_SEQ = 17'd65537;
  localparam logic [PEND_W-1:0] SEQ_SPAN   = 17'd65536;

  typedef struct packed {
    logic [PROB_W-1:0]     min_sequential;
    logic [CFG_DATA_W-1:0] max_dropout;
    logic [CFG_DATA_W-1:0] max_misorder;
  } cfg_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  base_seq;
    logic [SEQ_W-1:0]  max_seq;
    logic [SEQ_W-1:0]  cycles;
    logic [CNT_W-1:0]  received;
    logic [PROB_W-1:0] probation;
    logic [PEND_W-1:0] bad_seq;
  } seq_state_t;

  typedef struct packed {
    logic             cmd;
    logic [SEQ_W-1:0] seq;
  } item_t;

endpackage

### rtl/core/rtpsv_cfg_regs.sv
module rtpsv_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [rtpsv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtpsv_pkg::CFG_DATA_W-1:0] cfg_data,
  output rtpsv_pkg::cfg_t                  cfg
);

  rtpsv_pkg::cfg_t cfg_r;
  rtpsv_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        rtpsv_pkg::CFG_MIN_SEQUENTIAL:
          cfg_nxt.min_sequential = cfg_data[rtpsv_pkg::PROB_W-1:0];
        rtpsv_pkg::CFG_MAX_DROPOUT:  cfg_nxt.max_dropout  = cfg_data;
        rtpsv_pkg::CFG_MAX_MISORDER: cfg_nxt.max_misorder = cfg_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_sequential <= rtpsv_pkg::RST_MIN_SEQUENTIAL;
      cfg_r.max_dropout    <= rtpsv_pkg::RST_MAX_DROPOUT;
      cfg_r.max_misorder   <= rtpsv_pkg::RST_MAX_MISORDER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/rtpsv_seq_update.sv
module rtpsv_seq_update (
  input  rtpsv_pkg::cfg_t       cfg,
  input  rtpsv_pkg::seq_state_t st,
  input  rtpsv_pkg::item_t      item,
  output rtpsv_pkg::seq_state_t st_nxt,
  output logic                  accepted
);

  logic [rtpsv_pkg::SEQ_W-1:0]  udelta;
  logic [rtpsv_pkg::SEQ_W-1:0]  next_in_order;
  logic [rtpsv_pkg::PROB_W-1:0] prob_dec;
  logic [rtpsv_pkg::PEND_W-1:0] misorder_bound;

  function automatic rtpsv_pkg::seq_state_t restart(rtpsv_pkg::seq_state_t cur,
                                                    logic [rtpsv_pkg::SEQ_W-1:0] s);
    rtpsv_pkg::seq_state_t r;
    r          = cur;
    r.base_seq = s;
    r.max_seq  = s;
    r.bad_seq  = rtpsv_pkg::NO_BAD_SEQ;
    r.cycles   = '0;
    r.received = '0;
    return r;
  endfunction

  assign udelta         = item.seq - st.max_seq;
  assign next_in_order  = st.max_seq + 16'd1;
  assign prob_dec       = st.probation - 4'd1;
  assign misorder_bound = rtpsv_pkg::SEQ_SPAN - {2'b00, cfg.max_misorder};

  always_comb begin
    st_nxt   = st;
    accepted = 1'b0;
    if (item.cmd) begin
      st_nxt           = restart(st, item.seq);
      st_nxt.max_seq   = item.seq - 16'd1;
      st_nxt.probation = cfg.min_sequential;
    end else if (st.probation != '0) begin
      st_nxt.max_seq = item.seq;
      if (item.seq == next_in_order) begin
        st_nxt.probation = prob_dec;
        if (prob_dec == '0) begin
          st_nxt          = restart(st_nxt, item.seq);
          st_nxt.received = 32'd1;
          accepted        = 1'b1;
        end
      end else begin
        st_nxt.probation = (cfg.min_sequential == '0) ? '0 : cfg.min_sequential - 4'd1;
      end
    end else begin
      accepted        = 1'b1;
      st_nxt.received = st.received + 32'd1;
      if (udelta < {1'b0, cfg.max_dropout}) begin
        // forward step: a smaller number means the sequence went round
        if (item.seq < st.max_seq) st_nxt.cycles = st.cycles + 16'd1;
        st_nxt.max_seq = item.seq;
      end else if ({1'b0, udelta} <= misorder_bound) begin
        if ({1'b0, item.seq} == st.bad_seq) begin
          st_nxt          = restart(st, item.seq);
          st_nxt.received = 32'd1;
        end else begin
          // large jump: remember it, accept only if the next one follows
          st_nxt.received = st.received;
          st_nxt.bad_seq  = {1'b0, item.seq + 16'd1};
          accepted        = 1'b0;
        end
      end
    end
  end

endmodule

### rtl/core/rtp_sequence_validator_top.sv
// rtp sequence number validator
// input channel: in_tuser is the command (0 check packet, 1 start a new source
// at this sequence number), in_tdata the 16-bit sequence number
// output channel: one transaction per input transaction, in order; out_tuser
// is the accepted flag, out_tdata carries highest sequence, wrap count,
// received count and base sequence as they stand after the packet
// config channel: cfg_index 0 min_sequential, 1 max_dropout, 2 max_misorder;
// cfg_ready is always high, writes to index 3 are dropped; write only while
// no transaction is in flight
// latency: a transaction accepted at one edge is registered, processed at the
// next edge into the output register and shows on out_tvalid after that edge
// throughput: one transaction per cycle; the state update is a single
// compare-and-increment pass between the input register and the state and
// output registers
// reset (rst_n low, synchronous) empties both registers, restores the
// register defaults and clears the source state
// when the receiver stalls the output register holds, the input register
// takes one more transaction, then in_tready drops until the output moves
module rtp_sequence_validator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,  // [15:0] seq
  input  logic                             in_tuser,  // [0] cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] highest_seq, [31:16] wrap_count, [63:32] received_count,
  // [79:64] base_seq
  output logic [rtpsv_pkg::OUT_W-1:0]      out_tdata,
  output logic                             out_tuser, // [0] accepted
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rtpsv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtpsv_pkg::CFG_DATA_W-1:0] cfg_data
);

  rtpsv_pkg::cfg_t       cfg;
  rtpsv_pkg::item_t      item_r;
  logic                  item_valid_r;
  rtpsv_pkg::seq_state_t st_r;
  rtpsv_pkg::seq_state_t st_nxt;
  logic                  accepted_nxt;
  logic                  out_valid_r;
  logic [rtpsv_pkg::OUT_W-1:0] out_data_r;
  logic                  out_user_r;
  logic                  fire;

  assign cfg_ready = 1'b1;

  rtpsv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rtpsv_seq_update u_upd (
    .cfg      (cfg),
    .st       (st_r),
    .item     (item_r),
    .st_nxt   (st_nxt),
    .accepted (accepted_nxt)
  );

  // process when the output register is empty or being drained
  assign fire      = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.cmd <= in_tuser;
      item_r.seq <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.base_seq  <= '0;
      st_r.max_seq   <= '0;
      st_r.cycles    <= '0;
      st_r.received  <= '0;
      st_r.probation <= '0;
      st_r.bad_seq   <= rtpsv_pkg::NO_BAD_SEQ;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {st_nxt.base_seq, st_nxt.received, st_nxt.cycles, st_nxt.max_seq};
      out_user_r <= accepted_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### rtl/core/rtpsv_checker.sv
`include "rtp_sequence_validator_top_macros.svh"

module rtpsv_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [rtpsv_pkg::OUT_W-1:0] out_tdata,
  input logic                        out_tuser
);

  `RTPSV_ASSERT_ALWAYS(a_reset_empties, !rst_n, !out_tvalid, "output valid right after reset")
  `RTPSV_ASSERT_NOW(a_rose_needs_input, $rose(out_tvalid), $past(in_tvalid && in_tready, 2), "result without an input transaction two cycles before")
  `RTPSV_ASSERT_NOW(a_backpressure_only, !in_tready, out_tvalid && !out_tready, "input stalled while output free")
  `RTPSV_ASSERT_NEXT(a_stall_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind rtp_sequence_validator_top rtpsv_checker u_rtpsv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
